### sv/fpsc_pkg.sv
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared types and constants of the frame packer with additive checksum.
// ----------------------------------------------------------------------------
package fpsc_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned STEP_W    = 3;

  // command field codes
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BODY  = 1'b1
  } cmd_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PROTO    = CFG_IDX_W'(1);

  // word positions of a start sequence
  localparam logic [STEP_W-1:0] STEP_PRE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_PROTO = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MSG   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LEN3  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LEN2  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LEN1  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_LEN0  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_CSUM  = 3'd7;

  // word positions of a body sequence
  localparam logic [STEP_W-1:0] BODY_DATA  = 3'd0;
  localparam logic [STEP_W-1:0] BODY_CSUM  = 3'd1;

  // queue geometry
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // one classified operation handed from front to back
  typedef struct packed {
    cmd_e              kind;
    logic              close;   // frame ends with this op: append checksum
    logic [DATA_W-1:0] data;    // msg type for start, body word for body
    logic [LEN_W-1:0]  len;
  } op_t;

endpackage

### sv/fpsc_if.sv
// ----------------------------------------------------------------------------
// fpsc channel interfaces
// Valid/ready channels for input items, output words and register writes.
// ----------------------------------------------------------------------------
interface fpsc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [fpsc_pkg::DATA_W-1:0]   msg_type;
  logic [fpsc_pkg::LEN_W-1:0]    body_length;
  logic [fpsc_pkg::DATA_W-1:0]   body_byte;

  modport source (output valid, command, msg_type, body_length, body_byte,
                  input ready);
  modport sink   (input valid, command, msg_type, body_length, body_byte,
                  output ready);
endinterface

interface fpsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [fpsc_pkg::DATA_W-1:0]   out_byte;
  logic                          end_of_frame;
  logic                          last_of_run;

  modport source (output valid, out_byte, end_of_frame, last_of_run,
                  input ready);
  modport sink   (input valid, out_byte, end_of_frame, last_of_run,
                  output ready);
endinterface

interface fpsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpsc_pkg::CFG_IDX_W-1:0] index;
  logic [fpsc_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/fpsc_front.sv
// ----------------------------------------------------------------------------
// fpsc_front
// Accepts input items, tracks the open frame and queues classified ops.
// ----------------------------------------------------------------------------
module fpsc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  fpsc_in_if.sink          in_i,
  input  logic             q_full_i,
  output logic             push_o,
  output fpsc_pkg::op_t    op_o
);
  import fpsc_pkg::*;

  logic              open_q, open_d;
  logic [LEN_W-1:0]  remain_q, remain_d;
  logic              accept;
  logic              last_body;

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign last_body  = (remain_q == LEN_W'(1));

  always_comb begin
    open_d      = open_q;
    remain_d    = remain_q;
    push_o      = 1'b0;
    op_o.kind   = cmd_e'(in_i.command);
    op_o.len    = in_i.body_length;
    op_o.data   = in_i.body_byte;
    op_o.close  = 1'b0;
    if (cmd_e'(in_i.command) == CMD_START) begin
      op_o.data  = in_i.msg_type;
      op_o.close = (in_i.body_length == '0);
      if (accept) begin
        push_o   = 1'b1;
        open_d   = (in_i.body_length != '0);
        remain_d = in_i.body_length;
      end
    end else begin
      op_o.close = last_body;
      // body word with no frame open is dropped
      if (accept && open_q) begin
        push_o   = 1'b1;
        remain_d = remain_q - LEN_W'(1);
        open_d   = ~last_body;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      remain_q <= '0;
    end else begin
      open_q   <= open_d;
      remain_q <= remain_d;
    end
  end

  a_closed_no_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> remain_q == '0)
    else $error("front: words remaining with no frame open");

  a_open_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> remain_q != '0)
    else $error("front: open frame with zero words remaining");

endmodule

### sv/fpsc_queue.sv
// ----------------------------------------------------------------------------
// fpsc_queue
// Two-entry op queue between front and back.
// ----------------------------------------------------------------------------
module fpsc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fpsc_pkg::op_t    op_i,
  output logic             full_o,
  output logic             valid_o,
  output fpsc_pkg::op_t    op_o,
  input  logic             pop_i
);
  import fpsc_pkg::*;

  op_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("queue: pop while empty");

endmodule

### sv/fpsc_back.sv
// ----------------------------------------------------------------------------
// fpsc_back
// Expands queued ops into output words, one per cycle unless the output stalls, and keeps the sum.
// ----------------------------------------------------------------------------
module fpsc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fpsc_pkg::DATA_W-1:0] preamble_i,
  input  logic [fpsc_pkg::DATA_W-1:0] proto_i,
  input  logic                        q_valid_i,
  input  fpsc_pkg::op_t               op_i,
  output logic                        pop_o,
  fpsc_out_if.source                  out_o
);
  import fpsc_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0] sum_q, sum_d;
  logic              ovalid_q;
  logic [DATA_W-1:0] obyte_q;
  logic              oeof_q, olast_q;

  logic              adv, emit, at_last, is_sum;
  logic [STEP_W-1:0] last_step;
  logic [DATA_W-1:0] word;

  assign adv  = ~ovalid_q | out_o.ready;
  assign emit = q_valid_i & adv;

  always_comb begin
    if (op_i.kind == CMD_START) begin
      last_step = op_i.close ? STEP_CSUM : STEP_LEN0;
    end else begin
      last_step = op_i.close ? BODY_CSUM : BODY_DATA;
    end
  end

  assign at_last = (step_q == last_step);
  assign is_sum  = op_i.close & at_last;
  assign pop_o   = emit & at_last;

  always_comb begin
    word = sum_q;
    if (!is_sum) begin
      if (op_i.kind == CMD_START) begin
        case (step_q)
          STEP_PRE:   word = preamble_i;
          STEP_PROTO: word = proto_i;
          STEP_MSG:   word = op_i.data;
          STEP_LEN3:  word = op_i.len[31:24];
          STEP_LEN2:  word = op_i.len[23:16];
          STEP_LEN1:  word = op_i.len[15:8];
          STEP_LEN0:  word = op_i.len[7:0];
          default:    word = sum_q;
        endcase
      end else begin
        word = op_i.data;
      end
    end
  end

  always_comb begin
    step_d = step_q;
    sum_d  = sum_q;
    if (emit) begin
      step_d = at_last ? '0 : step_q + STEP_W'(1);
      if (is_sum) begin
        sum_d = '0;
      end else if (op_i.kind == CMD_START && step_q == STEP_PRE) begin
        sum_d = word;   // new frame restarts the sum
      end else begin
        sum_d = sum_q + word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      sum_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      sum_q  <= sum_d;
      if (adv) ovalid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q <= word;
      oeof_q  <= is_sum;
      olast_q <= at_last;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.out_byte     = obyte_q;
  assign out_o.end_of_frame = oeof_q;
  assign out_o.last_of_run  = olast_q;

  a_mid_op_has_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> q_valid_i)
    else $error("back: sequence in progress with empty queue");

  a_eof_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && oeof_q |-> olast_q)
    else $error("back: checksum word not flagged last");

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && is_sum |=> sum_q == '0)
    else $error("back: sum not cleared after checksum");

endmodule

### sv/frame_packer_with_sum_checksum_unit.sv
// ----------------------------------------------------------------------------
// frame_packer_with_sum_checksum_unit
// Length-prefixed frame packer with 8-bit additive checksum.
//
//   channel  dir  fields                                        word
//   in_i     in   command, msg_type, body_length, body_byte     one command
//   out_o    out  out_byte, end_of_frame, last_of_run           one frame byte
//   cfg_i    in   index, data                                   one reg write
//
// The back end emits one word per cycle unless out_o stalls: a body command
// yields one word (two when it closes the frame), a start seven (eight with
// zero length). A two-entry op queue decouples input from output, so body
// commands stream at one per cycle unless out_o stalls, while starts can fill the queue and hold the input back.
// Reset clears the open-frame state, the sum and both config registers.
// Output stalls back up through the queue; cfg_i is always ready.
// ----------------------------------------------------------------------------
module frame_packer_with_sum_checksum_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  fpsc_in_if.sink      in_i,
  fpsc_out_if.source   out_o,
  fpsc_cfg_if.sink     cfg_i
);
  import fpsc_pkg::*;

  logic [DATA_W-1:0] preamble_q, proto_q;
  logic              push, q_full, q_valid, pop;
  op_t               push_op, head_op;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= '0;
      proto_q    <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_PREAMBLE: preamble_q <= cfg_i.data;
        REG_PROTO:    proto_q    <= cfg_i.data;
        default:      ;
      endcase
    end
  end

  fpsc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (push_op)
  );

  fpsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (head_op),
    .pop_i   (pop)
  );

  fpsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .preamble_i (preamble_q),
    .proto_i    (proto_q),
    .q_valid_i  (q_valid),
    .op_i       (head_op),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
